FILE: hw/rtl/lpm_pkg.sv
// Shared types, constants and helpers for the IPv4 longest-prefix route table.
// Used by lpm_ctrl and the top level; no dependencies.
package lpm_pkg;

  // Table geometry
  localparam int MAX_ROUTES = 64;
  localparam int IDX_W      = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
  localparam int CNT_W      = $clog2(MAX_ROUTES + 1);

  // Field widths
  localparam int ADDR_W   = 32;
  localparam int PFX_W    = 6;
  localparam int METRIC_W = 16;
  localparam int COUNT_W  = 7;
  localparam int OP_W     = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [PFX_W-1:0] PFX_MAX = PFX_W'(32);

  // Item operation codes
  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_ADD    = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE = 1'b0,
    CFG_LOCAL  = 1'b1
  } cfg_idx_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // One stored route
  typedef struct packed {
    logic [ADDR_W-1:0]   net;
    logic [PFX_W-1:0]    pfx;
    logic [ADDR_W-1:0]   via;
    logic [METRIC_W-1:0] metric;
  } route_entry_t;

  localparam int ENTRY_W = $bits(route_entry_t);

  // Route memory access request from the controller
  typedef struct packed {
    logic         we;
    logic [IDX_W-1:0] waddr;
    route_entry_t wentry;
    logic         re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  // Netmask for a prefix length; lengths of 32 and above give all ones
  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PFX_W-1:0] pfx);
    logic [ADDR_W-1:0] m;
    if (pfx == '0) begin
      m = '0;
    end else if (pfx >= PFX_MAX) begin
      m = '1;
    end else begin
      m = ~({ADDR_W{1'b1}} >> pfx);
    end
    return m;
  endfunction

endpackage

FILE: hw/rtl/ipv4_longest_prefix_route_table.sv
// Top level of the IPv4 longest-prefix route table: stream ports, field
// packing, controller and route memory. Depends on lpm_pkg, lpm_ctrl,
// lpm_route_mem.
// Add, clear and unused codes: the item goes to ST_DONE, which registers the
// result word once the output register is free. Lookup: ST_SCAN reads one
// route memory entry per cycle and compares it, then ST_DONE registers the result.
// One item at a time: next word taken the cycle after the result registers.
// Reset (rst_n, sync, active low) empties the table and clears config regs.
module ipv4_longest_prefix_route_table (
  input  logic         clk,
  input  logic         rst_n,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  // dest_addr[31:0], route_net[63:32], route_prefix[69:64],
  // route_via[101:70], route_metric[117:102], zero pad[119:118]
  input  logic [119:0] in_tdata,
  // operation[1:0]
  input  logic [1:0]   in_tuser,
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[0], override[1], match_found[2], match_prefix[8:3],
  // match_via[40:9], match_metric[56:41], entry_count[63:57]
  output logic [63:0]  out_tdata,
  // configuration writes
  input  logic         cfg_we,
  input  logic [0:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata
);

  import lpm_pkg::*;

  mem_req_t     mem_req;
  route_entry_t mem_rdata;
  logic [ENTRY_W-1:0] rdata_raw;

  logic                status, override, match_found;
  logic [PFX_W-1:0]    match_prefix;
  logic [ADDR_W-1:0]   match_via;
  logic [METRIC_W-1:0] match_metric;
  logic [COUNT_W-1:0]  entry_count;

  lpm_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .operation    (in_tuser),
    .dest_addr    (in_tdata[31:0]),
    .route_net    (in_tdata[63:32]),
    .route_prefix (in_tdata[69:64]),
    .route_via    (in_tdata[101:70]),
    .route_metric (in_tdata[117:102]),
    .res_valid    (out_tvalid),
    .res_ready    (out_tready),
    .status       (status),
    .override     (override),
    .match_found  (match_found),
    .match_prefix (match_prefix),
    .match_via    (match_via),
    .match_metric (match_metric),
    .entry_count  (entry_count),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .mem_req      (mem_req),
    .mem_rdata    (mem_rdata)
  );

  lpm_route_mem #(
    .DATA_W (ENTRY_W),
    .DEPTH  (MAX_ROUTES),
    .AW     (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wentry),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (rdata_raw)
  );

  assign mem_rdata = route_entry_t'(rdata_raw);

  // Pack the result word
  assign out_tdata = {entry_count, match_metric, match_via, match_prefix,
                      match_found, override, status};

endmodule

FILE: hw/rtl/lpm_route_mem.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Registered read. No package dependency.
module lpm_route_mem #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 64,
  parameter int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/lpm_ctrl.sv
// Route table controller: item sequencing, add/clear, linear lookup scan,
// config registers and result register. Depends on lpm_pkg.
module lpm_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  // item input
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lpm_pkg::OP_W-1:0]      operation,
  input  logic [lpm_pkg::ADDR_W-1:0]    dest_addr,
  input  logic [lpm_pkg::ADDR_W-1:0]    route_net,
  input  logic [lpm_pkg::PFX_W-1:0]     route_prefix,
  input  logic [lpm_pkg::ADDR_W-1:0]    route_via,
  input  logic [lpm_pkg::METRIC_W-1:0]  route_metric,
  // result output
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic                          status,
  output logic                          override,
  output logic                          match_found,
  output logic [lpm_pkg::PFX_W-1:0]     match_prefix,
  output logic [lpm_pkg::ADDR_W-1:0]    match_via,
  output logic [lpm_pkg::METRIC_W-1:0]  match_metric,
  output logic [lpm_pkg::COUNT_W-1:0]   entry_count,
  // config writes
  input  logic                          cfg_we,
  input  logic [lpm_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [lpm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // route memory
  output lpm_pkg::mem_req_t             mem_req,
  input  lpm_pkg::route_entry_t         mem_rdata
);

  import lpm_pkg::*;

  state_t state_r, state_nxt;

  logic                enable_r;
  logic [ADDR_W-1:0]   local_r;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    rd_idx_r;
  logic                rvalid_r;
  logic [ADDR_W-1:0]   dest_r;

  logic                status_r;
  logic                found_r;
  logic [PFX_W-1:0]    best_pfx_r;
  logic [ADDR_W-1:0]   best_via_r;
  logic [METRIC_W-1:0] best_met_r;

  logic                out_valid_r;
  logic                out_status_r, out_ovr_r, out_found_r;
  logic [PFX_W-1:0]    out_pfx_r;
  logic [ADDR_W-1:0]   out_via_r;
  logic [METRIC_W-1:0] out_met_r;
  logic [COUNT_W-1:0]  out_cnt_r;

  logic                accept;
  logic                rd_en;
  logic                load_out;
  logic                full;
  logic [PFX_W-1:0]    add_pfx;
  logic [ADDR_W-1:0]   rd_mask;
  logic                hit;
  logic                ovr;

  assign accept  = in_valid && in_ready;
  assign full    = (count_r >= CNT_W'(MAX_ROUTES));
  assign add_pfx = (route_prefix > PFX_MAX) ? PFX_MAX : route_prefix;

  // Next-state logic
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (operation == OP_LOOKUP) ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (!rd_en && !rvalid_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_SCAN: rd_en    = (rd_idx_r < count_r);
      ST_DONE: load_out = !out_valid_r || res_ready;
      default: ;
    endcase
  end

  // Route memory request: store on add, one read per scan cycle
  always_comb begin
    mem_req.we            = accept && (operation == OP_ADD) && !full;
    mem_req.waddr         = count_r[IDX_W-1:0];
    mem_req.wentry.net    = route_net & prefix_mask(add_pfx);
    mem_req.wentry.pfx    = add_pfx;
    mem_req.wentry.via    = route_via;
    mem_req.wentry.metric = route_metric;
    mem_req.re            = rd_en;
    mem_req.raddr         = rd_idx_r[IDX_W-1:0];
  end

  // Entry count update
  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      case (operation)
        OP_ADD:   if (!full) count_nxt = count_r + CNT_W'(1);
        OP_CLEAR: count_nxt = '0;
        default:  ;
      endcase
    end
  end

  // Compare stage on the word returned by the memory
  assign rd_mask = prefix_mask(mem_rdata.pfx);
  assign hit     = rvalid_r && ((dest_r & rd_mask) == (mem_rdata.net & rd_mask))
                   && (mem_rdata.pfx > best_pfx_r);

  assign ovr = found_r && enable_r && (local_r != '0) && (dest_r != local_r);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      enable_r    <= 1'b0;
      local_r     <= '0;
      count_r     <= '0;
      rd_idx_r    <= '0;
      rvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      rvalid_r <= rd_en;
      if (accept) begin
        rd_idx_r <= '0;
      end else if (rd_en) begin
        rd_idx_r <= rd_idx_r + CNT_W'(1);
      end
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_addr))
          CFG_ENABLE: enable_r <= cfg_wdata[0];
          CFG_LOCAL:  local_r  <= cfg_wdata[ADDR_W-1:0];
          default:    ;
        endcase
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working result and best-match registers
  always_ff @(posedge clk) begin
    if (accept) begin
      dest_r     <= dest_addr;
      status_r   <= (operation == OP_ADD) && full;
      found_r    <= 1'b0;
      best_pfx_r <= '0;
      best_via_r <= '0;
      best_met_r <= '0;
    end else if (hit) begin
      found_r    <= 1'b1;
      best_pfx_r <= mem_rdata.pfx;
      best_via_r <= mem_rdata.via;
      best_met_r <= mem_rdata.metric;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r <= status_r;
      out_ovr_r    <= ovr;
      out_found_r  <= found_r;
      out_pfx_r    <= best_pfx_r;
      out_via_r    <= best_via_r;
      out_met_r    <= best_met_r;
      out_cnt_r    <= COUNT_W'(count_r);
    end
  end

  assign res_valid    = out_valid_r;
  assign status       = out_status_r;
  assign override     = out_ovr_r;
  assign match_found  = out_found_r;
  assign match_prefix = out_pfx_r;
  assign match_via    = out_via_r;
  assign match_metric = out_met_r;
  assign entry_count  = out_cnt_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ROUTES))
    else $error("route count above table size");

  a_rvalid_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rvalid_r |-> (state_r == ST_SCAN))
    else $error("memory read data outside scan");

  a_add_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (operation == OP_ADD) && !full) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("add did not advance count");

  a_best_pfx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    best_pfx_r <= PFX_MAX)
    else $error("best prefix above 32");

endmodule
